// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define SIDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failure");

// next-cycle implication, disabled while in reset
`define SIDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failure");

`else

`define SIDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SIDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/sida_pkg.sv -----
// ----------------------------------------------------------------------------
// sida_pkg
// types and constants for the signed integer to decimal text converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sida_pkg;

	localparam int NUM_BITS   = 32;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int IDX_W      = $clog2(NUM_DIGITS);
	localparam int CNT_W      = $clog2(NUM_BITS);
	localparam int CHAR_W     = 6;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_EMIT
	} state_t;

	// add-three correction of one decimal digit ahead of a left shift
	function automatic logic [DIGIT_W-1:0] bcd_adjust(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] r;
		begin
			r = (d >= 4'd5) ? (d + 4'd3) : d;
			return r;
		end
	endfunction

endpackage

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// converts a 32-bit two's complement integer to its decimal ascii text
// ----------------------------------------------------------------------------
// One request on the slave side carries a signed 32-bit number; the block
// returns its decimal text on the master side, one character per request,
// most significant first: a leading '-' for negative values, no leading
// zeros, a single '0' for zero, and tlast on the final character. The most
// negative value gives "-2147483648". The conversion runs on one shared
// shift-and-add-three unit (double dabble) that takes one magnitude bit per
// cycle; an accepted number is converted, its leading digit is found, and
// its characters (1 to 11) are then emitted, each waiting while the master
// side stalls. s_tready is high only while the sequencer is idle; the output
// register may still hold the last character of the previous number when the
// next one is taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] number

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] text_char, [7:6] zero
	output logic        m_tlast    // final_char
);

	// sequencer state
	sida_pkg::state_t                  state_q, state_d;
	logic [sida_pkg::CNT_W-1:0]        cnt_q;      // conversion bit count
	logic [sida_pkg::IDX_W-1:0]        idx_q;      // digit being emitted
	logic                              minus_q;    // '-' still to be sent

	// datapath
	logic [sida_pkg::NUM_BITS-1:0]     mag_q;      // magnitude, shifted out msb first
	sida_pkg::bcd_t                    bcd_q;      // decimal digits being built
	sida_pkg::bcd_t                    bcd_adj;    // digits after add-three
	logic [sida_pkg::IDX_W-1:0]        lead_idx;   // highest non-zero digit

	// output register
	logic                              out_valid_q;
	logic [sida_pkg::CHAR_W-1:0]       out_char_q;
	logic                              out_last_q;

	// control from the next-state logic
	logic                              accept;
	logic                              out_free;
	logic                              load_out;
	logic [sida_pkg::CHAR_W-1:0]       load_char;
	logic                              load_last;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// shared unit: add three to every digit of five or more
	always_comb begin
		for (int i = 0; i < sida_pkg::NUM_DIGITS; i++) begin
			bcd_adj[i] = sida_pkg::bcd_adjust(bcd_q[i]);
		end
	end

	// leading digit search, digit zero when the whole number is zero
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < sida_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[i] != '0) begin
				lead_idx = sida_pkg::IDX_W'(i);
			end
		end
	end

	// next state and character selection
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		load_out  = 1'b0;
		load_char = sida_pkg::CHAR_MINUS;
		load_last = 1'b0;
		unique case (state_q)
			sida_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = sida_pkg::ST_CONV;
				end
			end
			sida_pkg::ST_CONV: begin
				if (cnt_q == sida_pkg::CNT_W'(sida_pkg::NUM_BITS - 1)) begin
					state_d = sida_pkg::ST_FIND;
				end
			end
			sida_pkg::ST_FIND: begin
				state_d = sida_pkg::ST_EMIT;
			end
			sida_pkg::ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					if (minus_q) begin
						load_char = sida_pkg::CHAR_MINUS;
						load_last = 1'b0;
					end else begin
						load_char = sida_pkg::CHAR_ZERO + {2'b00, bcd_q[idx_q]};
						load_last = (idx_q == '0);
						if (idx_q == '0) begin
							state_d = sida_pkg::ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = sida_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sida_pkg::ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			minus_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q   <= '0;
				minus_q <= s_tdata[sida_pkg::NUM_BITS-1];
			end else if (state_q == sida_pkg::ST_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == sida_pkg::ST_FIND) begin
				idx_q <= lead_idx;
			end else if (load_out) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= s_tdata[sida_pkg::NUM_BITS-1] ? (~s_tdata + 32'd1) : s_tdata;
			bcd_q <= '0;
		end else if (state_q == sida_pkg::ST_CONV) begin
			// shift magnitude msb into the adjusted digits, top bit falls off
			bcd_q <= sida_pkg::bcd_t'({bcd_adj, mag_q[sida_pkg::NUM_BITS-1]});
			mag_q <= {mag_q[sida_pkg::NUM_BITS-2:0], 1'b0};
		end
		if (load_out) begin
			out_char_q <= load_char;
			out_last_q <= load_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_char_q};
	assign m_tlast  = out_last_q;

	// checks
	`SIDA_ASSERT_NXT(a_accept_starts_conv, clk, arst_n, accept,
		(state_q == sida_pkg::ST_CONV) && (cnt_q == '0))
	`SIDA_ASSERT_NXT(a_conv_length, clk, arst_n,
		(state_q == sida_pkg::ST_CONV) && (cnt_q == 5'd31), state_q == sida_pkg::ST_FIND)
	`SIDA_ASSERT_NXT(a_lead_in_range, clk, arst_n, state_q == sida_pkg::ST_FIND,
		idx_q <= 4'd9)
	`SIDA_ASSERT_IMP(a_char_legal, clk, arst_n, m_tvalid,
		(m_tdata == 8'd45) || ((m_tdata >= 8'd48) && (m_tdata <= 8'd57)))
	`SIDA_ASSERT_IMP(a_minus_not_last, clk, arst_n, m_tvalid && (m_tdata == 8'd45),
		!m_tlast)

endmodule
